[rtl/ipde_pkg.sv]
// Package for the IR pulse-distance encoder: widths, constants, register
// indexes and the structs passed between the sequencer, the cycle unit and the top level.
// No dependencies.
package ipde_pkg;

    localparam int DUR_W   = 20;
    localparam int FREQ_W  = 20;
    localparam int CYC_W   = 31;
    localparam int PROD_W  = DUR_W + FREQ_W + 1;
    localparam int QUO_W   = 21;
    localparam int REM_W   = 20;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 4;

    localparam int MAX_BITS_PER_ITEM = 8;
    localparam int MUL_STEPS         = FREQ_W;
    localparam int DIV_STEPS         = QUO_W;

    localparam logic [FREQ_W-1:0] DEFAULT_FREQ_HZ = FREQ_W'(38000);
    localparam logic [PROD_W-1:0] ROUND_BIAS      = PROD_W'(500000);
    localparam logic [QUO_W-1:0]  CYC_DIVISOR     = QUO_W'(1000000);

    typedef enum logic [IDX_W-1:0] {
        REG_CARRIER_FREQ = 3'd0,
        REG_HEADER_MARK  = 3'd1,
        REG_HEADER_SPACE = 3'd2,
        REG_BIT_MARK     = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_ONE_SPACE    = 3'd5,
        REG_GAP          = 3'd6,
        REG_MSB_LEAD     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  header_mark;
        logic [DUR_W-1:0]  header_space;
        logic [DUR_W-1:0]  bit_mark;
        logic [DUR_W-1:0]  zero_space;
        logic [DUR_W-1:0]  one_space;
        logic [DUR_W-1:0]  gap;
        logic              msb_lead;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DUR_W-1:0]  dur;
        logic [FREQ_W-1:0] freq;
    } t_calc_req;

    typedef struct packed {
        logic             done;
        logic [CYC_W-1:0] cyc_m1;
    } t_calc_rsp;

    typedef struct packed {
        logic             is_mark;
        logic [CYC_W-1:0] cyc_m1;
        logic             last;
    } t_word;

    typedef struct packed {
        logic  valid;
        t_word word;
    } t_push;

endpackage

[rtl/ipde_cyc.sv]
// Pulse length unit: bit-serial multiply of duration by frequency, then
// restoring division by one million, one quotient bit per cycle.
// Depends on ipde_pkg.
module ipde_cyc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipde_pkg::t_calc_req  i_req,
    output ipde_pkg::t_calc_rsp  o_rsp
);
    import ipde_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_ustate;

    t_ustate             r_state;
    logic [4:0]          r_cnt;
    logic                r_done;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-2:0]   r_mcand;
    logic [FREQ_W-1:0]   r_mplier;
    logic [REM_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_quo;

    logic [PROD_W-1:0]   w_acc_sum;
    logic [QUO_W-1:0]    w_trial;
    logic [QUO_W-1:0]    w_diff;
    logic                w_ge;

    assign w_acc_sum = r_acc + (r_mplier[0] ? {1'b0, r_mcand} : '0);
    assign w_trial   = {r_rem, r_quo[QUO_W-1]};
    assign w_ge      = (w_trial >= CYC_DIVISOR);
    assign w_diff    = w_trial - CYC_DIVISOR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_acc    <= ROUND_BIAS;
                        r_mcand  <= {{(PROD_W-1-DUR_W){1'b0}}, i_req.dur};
                        r_mplier <= i_req.freq;
                        r_cnt    <= '0;
                        r_state  <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_acc    <= w_acc_sum;
                    r_mcand  <= {r_mcand[PROD_W-3:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[FREQ_W-1:1]};
                    if (r_cnt == 5'(MUL_STEPS - 1)) begin
                        // high part is already below the divisor
                        r_rem   <= w_acc_sum[PROD_W-1:QUO_W];
                        r_quo   <= w_acc_sum[QUO_W-1:0];
                        r_cnt   <= '0;
                        r_state <= U_DIV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                U_DIV: begin
                    r_rem <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], w_ge};
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    // result held until the next request ends its multiply; a zero quotient counts as one carrier cycle
    assign o_rsp.done   = r_done;
    assign o_rsp.cyc_m1 = (r_quo == '0) ? '0
                        : ({{(CYC_W-QUO_W){1'b0}}, r_quo} - CYC_W'(1));

endmodule

[rtl/ipde_seq.sv]
// Pulse sequencer: walks header, payload bits and trailer of one item,
// skips zero-length pulses and holds one word back to mark the last one.
// Depends on ipde_pkg and ipde_cyc.
module ipde_seq #(
    parameter int MAX_BITS = ipde_pkg::MAX_BITS_PER_ITEM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ipde_pkg::t_cfg                i_cfg,
    input  logic [ipde_pkg::FREQ_W-1:0]   i_freq,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ipde_pkg::DATA_W-1:0]   i_data_byte,
    input  logic [ipde_pkg::CNT_W-1:0]    i_bit_count,
    input  logic                          i_frame_start,
    input  logic                          i_frame_end,
    output ipde_pkg::t_push               o_push,
    input  logic                          i_push_rdy
);
    import ipde_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEL   = 5'b00010,
        S_CALC  = 5'b00100,
        S_PUSH  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    typedef enum logic [6:0] {
        PH_HM   = 7'b0000001,
        PH_HS   = 7'b0000010,
        PH_BM   = 7'b0000100,
        PH_BS   = 7'b0001000,
        PH_TM   = 7'b0010000,
        PH_GAP  = 7'b0100000,
        PH_DONE = 7'b1000000
    } t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic                r_end;
    logic [CNT_W-1:0]    r_left;
    logic [DATA_W-1:0]   r_bits;
    logic                r_mark;
    logic                r_req_start;
    logic                r_pend_v;
    logic                r_pend_mark;
    logic [CYC_W-1:0]    r_pend_cyc;

    t_calc_req           w_req;
    t_calc_rsp           w_rsp;
    logic                w_accept;
    logic [CNT_W-1:0]    w_cnt_sat;
    logic [CNT_W-1:0]    w_align;
    t_phase              w_first;
    t_phase              w_after_bits;
    t_phase              w_phase_next;
    logic                w_bit;
    logic [DUR_W-1:0]    w_dur;
    logic                w_is_mark;
    logic                w_adv;

    ipde_cyc u_cyc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_req.start = r_req_start;
    assign w_req.dur   = w_dur;
    assign w_req.freq  = i_freq;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    assign w_cnt_sat = (i_bit_count > CNT_W'(MAX_BITS))
                     ? CNT_W'(MAX_BITS) : i_bit_count;
    assign w_align   = CNT_W'(DATA_W) - w_cnt_sat;

    always_comb begin
        priority if (i_frame_start) begin
            w_first = PH_HM;
        end else if (w_cnt_sat != '0) begin
            w_first = PH_BM;
        end else if (i_frame_end) begin
            w_first = PH_TM;
        end else begin
            w_first = PH_DONE;
        end
    end

    assign w_after_bits = r_end ? PH_TM : PH_DONE;
    assign w_bit        = i_cfg.msb_lead ? r_bits[DATA_W-1] : r_bits[0];

    always_comb begin
        unique case (r_phase)
            PH_HM: begin
                w_phase_next = PH_HS;
                w_dur        = i_cfg.header_mark;
                w_is_mark    = 1'b1;
            end
            PH_HS: begin
                w_phase_next = (r_left != '0) ? PH_BM : w_after_bits;
                w_dur        = i_cfg.header_space;
                w_is_mark    = 1'b0;
            end
            PH_BM: begin
                w_phase_next = PH_BS;
                w_dur        = i_cfg.bit_mark;
                w_is_mark    = 1'b1;
            end
            PH_BS: begin
                w_phase_next = (r_left > CNT_W'(1)) ? PH_BM : w_after_bits;
                w_dur        = w_bit ? i_cfg.one_space : i_cfg.zero_space;
                w_is_mark    = 1'b0;
            end
            PH_TM: begin
                w_phase_next = PH_GAP;
                w_dur        = i_cfg.bit_mark;
                w_is_mark    = 1'b1;
            end
            PH_GAP: begin
                w_phase_next = PH_DONE;
                w_dur        = i_cfg.gap;
                w_is_mark    = 1'b0;
            end
            default: begin
                w_phase_next = PH_DONE;
                w_dur        = '0;
                w_is_mark    = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_adv = 1'b0;
        unique case (r_state)
            S_SEL:   w_adv = (r_phase != PH_DONE) && (w_dur == '0);
            S_CALC:  w_adv = w_rsp.done && !r_pend_v;
            S_PUSH:  w_adv = i_push_rdy;
            default: w_adv = 1'b0;
        endcase
    end

    always_comb begin
        o_push.valid        = (r_state == S_PUSH) || (r_state == S_FLUSH);
        o_push.word.is_mark = r_pend_mark;
        o_push.word.cyc_m1  = r_pend_cyc;
        o_push.word.last    = (r_state == S_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_DONE;
            r_req_start <= 1'b0;
            r_pend_v    <= 1'b0;
            r_left      <= '0;
        end else begin
            r_req_start <= 1'b0;

            if (w_adv) begin
                r_phase <= w_phase_next;
                if (r_phase == PH_BS) begin
                    r_left <= r_left - CNT_W'(1);
                    r_bits <= i_cfg.msb_lead ? {r_bits[DATA_W-2:0], 1'b0}
                                             : {1'b0, r_bits[DATA_W-1:1]};
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_phase  <= w_first;
                        r_end    <= i_frame_end;
                        r_left   <= w_cnt_sat;
                        r_bits   <= i_cfg.msb_lead ? (i_data_byte << w_align)
                                                   : i_data_byte;
                        r_pend_v <= 1'b0;
                        r_state  <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_phase == PH_DONE) begin
                        r_state <= r_pend_v ? S_FLUSH : S_IDLE;
                    end else if (w_dur != '0) begin
                        r_req_start <= 1'b1;
                        r_mark      <= w_is_mark;
                        r_state     <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_rsp.done) begin
                        if (r_pend_v) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_pend_v    <= 1'b1;
                            r_pend_mark <= r_mark;
                            r_pend_cyc  <= w_rsp.cyc_m1;
                            r_state     <= S_SEL;
                        end
                    end
                end
                S_PUSH: begin
                    if (i_push_rdy) begin
                        r_pend_mark <= r_mark;
                        r_pend_cyc  <= w_rsp.cyc_m1;
                        r_state     <= S_SEL;
                    end
                end
                S_FLUSH: begin
                    if (i_push_rdy) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/ir_pulse_distance_encoder.sv]
// Top level of the IR pulse-distance encoder: configuration registers,
// sequencer instance and the output register.
// Depends on ipde_pkg and ipde_seq.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    data_byte, bit_count, frame_start, frame_end
//  output   out        o_out_valid / i_out_stall  is_mark, cycles_minus_one, last
//  config   in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Each emitted pulse word needs the pulse length unit, which runs a
// 20-step serial multiply and a 21-step division by one million. A zero-length
// pulse is skipped without a calculation. One item is worked on at a time.
// Reset is synchronous and active low; registers return to their default timings.
// Output stalls hold the sequencer; the output register lets the last word wait.
module ir_pulse_distance_encoder #(
    parameter int MAX_BITS = ipde_pkg::MAX_BITS_PER_ITEM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ipde_pkg::DATA_W-1:0]   i_data_byte,
    input  logic [ipde_pkg::CNT_W-1:0]    i_bit_count,
    input  logic                          i_frame_start,
    input  logic                          i_frame_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_is_mark,
    output logic [ipde_pkg::CYC_W-1:0]    o_cycles_minus_one,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [ipde_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [ipde_pkg::CFG_W-1:0]    i_cfg_data
);
    import ipde_pkg::*;

    t_cfg               r_cfg;
    logic               r_out_v;
    t_word              r_out;

    logic [FREQ_W-1:0]  w_freq;
    t_push              w_push;
    logic               w_push_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq         <= DEFAULT_FREQ_HZ;
            r_cfg.header_mark  <= DUR_W'(9000);
            r_cfg.header_space <= DUR_W'(4500);
            r_cfg.bit_mark     <= DUR_W'(560);
            r_cfg.zero_space   <= DUR_W'(560);
            r_cfg.one_space    <= DUR_W'(1690);
            r_cfg.gap          <= DUR_W'(40000);
            r_cfg.msb_lead     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CARRIER_FREQ: r_cfg.freq         <= i_cfg_data;
                REG_HEADER_MARK:  r_cfg.header_mark  <= i_cfg_data;
                REG_HEADER_SPACE: r_cfg.header_space <= i_cfg_data;
                REG_BIT_MARK:     r_cfg.bit_mark     <= i_cfg_data;
                REG_ZERO_SPACE:   r_cfg.zero_space   <= i_cfg_data;
                REG_ONE_SPACE:    r_cfg.one_space    <= i_cfg_data;
                REG_GAP:          r_cfg.gap          <= i_cfg_data;
                REG_MSB_LEAD:     r_cfg.msb_lead     <= i_cfg_data[0];
                default:          r_cfg.msb_lead     <= r_cfg.msb_lead;
            endcase
        end
    end

    assign w_freq = (r_cfg.freq == '0) ? DEFAULT_FREQ_HZ : r_cfg.freq;

    ipde_seq #(
        .MAX_BITS (MAX_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_freq        (w_freq),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_bit_count   (i_bit_count),
        .i_frame_start (i_frame_start),
        .i_frame_end   (i_frame_end),
        .o_push        (w_push),
        .i_push_rdy    (w_push_rdy)
    );

    assign w_push_rdy = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_push.valid && w_push_rdy) begin
            r_out_v <= 1'b1;
            r_out   <= w_push.word;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_v;
    assign o_is_mark          = r_out.is_mark;
    assign o_cycles_minus_one = r_out.cyc_m1;
    assign o_last             = r_out.last;

endmodule
